[src/mtep_pkg.sv]
// Shared types and constants for the MIDI track event parser.
`timescale 1ns / 1ps

package mtep_pkg;

    // Status byte class boundaries and special codes.
    localparam logic [7:0] STATUS_NOTE_LO  = 8'h80;
    localparam logic [7:0] STATUS_NOTE_HI  = 8'h9F;
    localparam logic [7:0] STATUS_TWO_LO   = 8'hA0;
    localparam logic [7:0] STATUS_TWO_HI   = 8'hBF;
    localparam logic [7:0] STATUS_ONE_LO   = 8'hC0;
    localparam logic [7:0] STATUS_ONE_HI   = 8'hDF;
    localparam logic [7:0] STATUS_BEND_LO  = 8'hE0;
    localparam logic [7:0] STATUS_BEND_HI  = 8'hEF;
    localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_CT = 8'hF7;
    localparam logic [7:0] STATUS_META     = 8'hFF;
    localparam logic [7:0] META_TEMPO      = 8'h51;
    localparam logic [7:0] META_EOT        = 8'h2F;

    localparam int DELTA_W = 28;
    localparam int TEMPO_W = 24;
    localparam int KEY_W   = 7;

    typedef enum logic [3:0] {
        PH_DELTA  = 4'd0,
        PH_STATUS = 4'd1,
        PH_KEY    = 4'd2,
        PH_MTYPE  = 4'd3,
        PH_LEN    = 4'd4,
        PH_SKIP   = 4'd5,
        PH_TEMPO  = 4'd6
    } t_phase;

    // Class of a byte when it is read as a status byte.
    typedef enum logic [2:0] {
        CLS_NOTE  = 3'd0,
        CLS_SKIP2 = 3'd1,
        CLS_SKIP1 = 3'd2,
        CLS_SYSEX = 3'd3,
        CLS_META  = 3'd4,
        CLS_BAD   = 3'd5
    } t_class;

    typedef enum logic [1:0] {
        KIND_NOTE  = 2'd0,
        KIND_TEMPO = 2'd1,
        KIND_EOT   = 2'd2,
        KIND_BAD   = 2'd3
    } t_kind;

    // One classified byte as it travels from the front end to the parser.
    typedef struct packed {
        logic [7:0] data;
        logic       track_start;
        t_class     cls;
        logic       is_eot;
        logic       is_tempo;
    } t_token;

endpackage

[src/mtep_front.sv]
// Front end: accepts raw bytes, classifies them and pushes them into the queue.
`timescale 1ns / 1ps

module mtep_front (
    input  logic               i_data_byte_valid,
    input  logic [7:0]         i_data_byte,
    input  logic               i_track_start,
    input  logic               i_queue_full,
    output logic               o_ready,
    output logic               o_push,
    output mtep_pkg::t_token   o_token
);

    mtep_pkg::t_class w_cls;

    always_comb begin
        if (i_data_byte inside {[mtep_pkg::STATUS_NOTE_LO:mtep_pkg::STATUS_NOTE_HI]}) begin
            w_cls = mtep_pkg::CLS_NOTE;
        end else if (i_data_byte inside {[mtep_pkg::STATUS_TWO_LO:mtep_pkg::STATUS_TWO_HI],
                                         [mtep_pkg::STATUS_BEND_LO:mtep_pkg::STATUS_BEND_HI]}) begin
            w_cls = mtep_pkg::CLS_SKIP2;
        end else if (i_data_byte inside {[mtep_pkg::STATUS_ONE_LO:mtep_pkg::STATUS_ONE_HI]}) begin
            w_cls = mtep_pkg::CLS_SKIP1;
        end else if (i_data_byte inside {mtep_pkg::STATUS_SYSEX, mtep_pkg::STATUS_SYSEX_CT}) begin
            w_cls = mtep_pkg::CLS_SYSEX;
        end else if (i_data_byte == mtep_pkg::STATUS_META) begin
            w_cls = mtep_pkg::CLS_META;
        end else begin
            w_cls = mtep_pkg::CLS_BAD;
        end
    end

    assign o_ready  = !i_queue_full;
    assign o_push   = i_data_byte_valid && !i_queue_full;

    assign o_token.data        = i_data_byte;
    assign o_token.track_start = i_track_start;
    assign o_token.cls         = w_cls;
    assign o_token.is_eot      = (i_data_byte == mtep_pkg::META_EOT);
    assign o_token.is_tempo    = (i_data_byte == mtep_pkg::META_TEMPO);

endmodule

[src/mtep_queue.sv]
// Short FIFO of classified bytes between the front end and the parser.
`timescale 1ns / 1ps

module mtep_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mtep_pkg::t_token  i_token,
    output logic              o_full,
    output logic              o_valid,
    output mtep_pkg::t_token  o_token,
    input  logic              i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mtep_pkg::t_token r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

endmodule

[src/mtep_back.sv]
// Back end: event parsing state machine and registered result stage.
`timescale 1ns / 1ps

module mtep_back #(
    parameter int VLQ_MAX_BYTES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  mtep_pkg::t_token   i_token,
    output logic               o_pop,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_event_kind,
    output logic [27:0]        o_delta_ticks,
    output logic [6:0]         o_key_number,
    output logic [23:0]        o_tempo_value
);

    mtep_pkg::t_phase r_phase, n_phase;
    logic [27:0]      r_delta, n_delta;
    logic [1:0]       r_vlq_cnt, n_vlq_cnt;
    logic             r_is_meta, n_is_meta;
    logic             r_is_eot, n_is_eot;
    logic             r_is_tempo, n_is_tempo;
    logic [27:0]      r_remain, n_remain;
    logic [1:0]       r_pidx, n_pidx;
    logic [23:0]      r_tempo, n_tempo;

    logic             r_out_valid;
    mtep_pkg::t_kind  r_kind;
    logic [27:0]      r_out_delta;
    logic [6:0]       r_out_key;
    logic [23:0]      r_out_tempo;

    mtep_pkg::t_phase w_phase;
    logic [1:0]       w_cnt;
    logic [7:0]       w_b;
    logic             w_vlq_more;
    logic [27:0]      w_vlq_delta, w_vlq_len, w_rem_dec;
    logic             w_res;
    mtep_pkg::t_kind  w_res_kind;
    logic [6:0]       w_res_key;
    logic [23:0]      w_res_tempo;
    logic             w_out_free;

    assign w_b     = i_token.data;
    assign w_phase = i_token.track_start ? mtep_pkg::PH_DELTA : r_phase;
    assign w_cnt   = i_token.track_start ? 2'd0 : r_vlq_cnt;

    // Continuation bit set and the quantity has room for another byte.
    assign w_vlq_more  = w_b[7] && (({1'b0, w_cnt} + 3'd1) < 3'(VLQ_MAX_BYTES));
    assign w_vlq_delta = ((w_cnt == 2'd0) ? 28'd0 : {r_delta[20:0], 7'd0})
                         | {21'd0, w_b[6:0]};
    assign w_vlq_len   = ((w_cnt == 2'd0) ? 28'd0 : {r_remain[20:0], 7'd0})
                         | {21'd0, w_b[6:0]};
    assign w_rem_dec   = (r_remain != 28'd0) ? r_remain - 28'd1 : r_remain;

    always_comb begin
        n_phase     = w_phase;
        n_delta     = r_delta;
        n_vlq_cnt   = w_cnt;
        n_is_meta   = r_is_meta;
        n_is_eot    = r_is_eot;
        n_is_tempo  = r_is_tempo;
        n_remain    = r_remain;
        n_pidx      = r_pidx;
        n_tempo     = r_tempo;
        w_res       = 1'b0;
        w_res_kind  = mtep_pkg::KIND_NOTE;
        w_res_key   = 7'd0;
        w_res_tempo = r_tempo;
        case (w_phase)
            mtep_pkg::PH_DELTA: begin
                n_delta = w_vlq_delta;
                if (w_vlq_more) begin
                    n_vlq_cnt = w_cnt + 2'd1;
                end else begin
                    n_vlq_cnt = 2'd0;
                    n_phase   = mtep_pkg::PH_STATUS;
                end
            end
            mtep_pkg::PH_STATUS: begin
                n_vlq_cnt = 2'd0;
                n_is_meta = (i_token.cls == mtep_pkg::CLS_META);
                case (i_token.cls)
                    mtep_pkg::CLS_NOTE: n_phase = mtep_pkg::PH_KEY;
                    mtep_pkg::CLS_SKIP2: begin
                        n_remain = 28'd2;
                        n_phase  = mtep_pkg::PH_SKIP;
                    end
                    mtep_pkg::CLS_SKIP1: begin
                        n_remain = 28'd1;
                        n_phase  = mtep_pkg::PH_SKIP;
                    end
                    mtep_pkg::CLS_SYSEX: n_phase = mtep_pkg::PH_LEN;
                    mtep_pkg::CLS_META:  n_phase = mtep_pkg::PH_MTYPE;
                    default: begin
                        w_res      = 1'b1;
                        w_res_kind = mtep_pkg::KIND_BAD;
                        n_phase    = mtep_pkg::PH_DELTA;
                    end
                endcase
            end
            mtep_pkg::PH_KEY: begin
                w_res      = 1'b1;
                w_res_kind = mtep_pkg::KIND_NOTE;
                w_res_key  = w_b[6:0];
                n_remain   = 28'd1;
                n_phase    = mtep_pkg::PH_SKIP;
            end
            mtep_pkg::PH_MTYPE: begin
                n_is_eot   = i_token.is_eot;
                n_is_tempo = i_token.is_tempo;
                n_vlq_cnt  = 2'd0;
                n_phase    = mtep_pkg::PH_LEN;
            end
            mtep_pkg::PH_LEN: begin
                n_remain = w_vlq_len;
                if (w_vlq_more) begin
                    n_vlq_cnt = w_cnt + 2'd1;
                end else begin
                    n_vlq_cnt = 2'd0;
                    if (r_is_meta && r_is_eot) begin
                        w_res      = 1'b1;
                        w_res_kind = mtep_pkg::KIND_EOT;
                        n_phase    = mtep_pkg::PH_DELTA;
                    end else if (r_is_meta && r_is_tempo) begin
                        n_pidx = 2'd0;
                        if (w_vlq_len == 28'd0) begin
                            w_res      = 1'b1;
                            w_res_kind = mtep_pkg::KIND_TEMPO;
                            n_phase    = mtep_pkg::PH_DELTA;
                        end else begin
                            n_phase = mtep_pkg::PH_TEMPO;
                        end
                    end else begin
                        n_phase = (w_vlq_len == 28'd0) ? mtep_pkg::PH_DELTA
                                                        : mtep_pkg::PH_SKIP;
                    end
                end
            end
            mtep_pkg::PH_SKIP: begin
                n_remain = w_rem_dec;
                if (w_rem_dec == 28'd0) begin
                    n_phase = mtep_pkg::PH_DELTA;
                end
            end
            mtep_pkg::PH_TEMPO: begin
                if (r_pidx != 2'd3) begin
                    n_tempo = {r_tempo[15:0], w_b};
                    n_pidx  = r_pidx + 2'd1;
                end
                n_remain = w_rem_dec;
                if (w_rem_dec == 28'd0) begin
                    w_res       = 1'b1;
                    w_res_kind  = mtep_pkg::KIND_TEMPO;
                    w_res_tempo = n_tempo;
                    n_phase     = mtep_pkg::PH_DELTA;
                end
            end
            default: begin
                n_phase   = mtep_pkg::PH_DELTA;
                n_vlq_cnt = 2'd0;
            end
        endcase
    end

    // A byte leaves the queue unless its result would overwrite one still waiting.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_pop      = i_q_valid && (!w_res || w_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= mtep_pkg::PH_DELTA;
            r_delta     <= '0;
            r_vlq_cnt   <= '0;
            r_is_meta   <= 1'b0;
            r_is_eot    <= 1'b0;
            r_is_tempo  <= 1'b0;
            r_remain    <= '0;
            r_pidx      <= '0;
            r_tempo     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase    <= n_phase;
                r_delta    <= n_delta;
                r_vlq_cnt  <= n_vlq_cnt;
                r_is_meta  <= n_is_meta;
                r_is_eot   <= n_is_eot;
                r_is_tempo <= n_is_tempo;
                r_remain   <= n_remain;
                r_pidx     <= n_pidx;
                r_tempo    <= n_tempo;
            end
            if (o_pop && w_res) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_res) begin
            r_kind      <= w_res_kind;
            r_out_delta <= r_delta;
            r_out_key   <= w_res_key;
            r_out_tempo <= w_res_tempo;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_kind;
    assign o_delta_ticks = r_out_delta;
    assign o_key_number  = r_out_key;
    assign o_tempo_value = r_out_tempo;

endmodule

[src/midi_track_event_parser_top.sv]
// Top level of the MIDI track event parser: front end, byte queue and parser.
// An accepted byte is first stored in the queue; the parser takes it from there
// and registers its event, if any, in the output stage.
// Throughput: one byte per cycle; a byte whose event finds one untaken is held.
// Reset (i_rst_n low, synchronous) empties the queue, drops any pending event and
// returns the parser to expecting a delta time with cleared state.
`timescale 1ns / 1ps

module midi_track_event_parser_top #(
    parameter int VLQ_MAX_BYTES = 4,
    parameter int QUEUE_DEPTH   = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_track_start,
    // Event result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_kind,
    output logic [27:0] o_delta_ticks,
    output logic [6:0]  o_key_number,
    output logic [23:0] o_tempo_value
);

    // The front end classifies each byte as if it were a status byte or a meta
    // type, so the parser only has to select on precomputed flags.
    mtep_pkg::t_token w_push_token;
    mtep_pkg::t_token w_pop_token;
    logic             w_push;
    logic             w_full;
    logic             w_q_valid;
    logic             w_pop;

    mtep_front u_front (
        .i_data_byte_valid (i_in_valid),
        .i_data_byte       (i_data_byte),
        .i_track_start     (i_track_start),
        .i_queue_full      (w_full),
        .o_ready           (o_in_ready),
        .o_push            (w_push),
        .o_token           (w_push_token)
    );

    // The queue lets the input side keep taking bytes, until it is full, while a
    // finished event waits on the output side.
    mtep_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_token (w_push_token),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_token (w_pop_token),
        .i_pop   (w_pop)
    );

    // The parser consumes one byte per cycle. A byte that produces an event is
    // held back only when the output register still holds an event that has not
    // been taken; bytes that produce nothing keep flowing.
    mtep_back #(
        .VLQ_MAX_BYTES (VLQ_MAX_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_token       (w_pop_token),
        .o_pop         (w_pop),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_event_kind  (o_event_kind),
        .o_delta_ticks (o_delta_ticks),
        .o_key_number  (o_key_number),
        .o_tempo_value (o_tempo_value)
    );

endmodule

[src/mtep_checker.sv]
// Port-level checker for the MIDI track event parser, bound to the top level.
`timescale 1ns / 1ps

module mtep_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_track_start,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_event_kind,
    input logic [27:0] o_delta_ticks,
    input logic [6:0]  o_key_number,
    input logic [23:0] o_tempo_value
);

    // A pending event stays offered until the transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("event dropped before its transaction completed");

    // No event is pending right after reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("event pending after reset");

    // Only note events carry a key.
    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind != mtep_pkg::KIND_NOTE) |-> (o_key_number == 7'd0))
        else $error("non-note event carries a key");

    // A pending event keeps its fields until the transaction completes.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready
        |=> $stable({o_event_kind, o_delta_ticks, o_key_number, o_tempo_value}))
        else $error("event fields changed before its transaction completed");

endmodule

bind midi_track_event_parser_top mtep_checker u_mtep_checker (.*);

[sim/tb_midi_track_event_parser_top.sv]
// Self-checking testbench for the MIDI track event parser top level.
`timescale 1ns / 1ps

module tb_midi_track_event_parser_top;

    // Longest variable-length quantity the parser takes, in bytes.
    localparam int VLQ_MAX      = 4;
    // Minimum number of random track bytes offered after the directed script.
    localparam int RANDOM_ITEMS = 1025;
    // Length of the long receiver hold-off that fills the byte queue.
    localparam int HOLD_CYCLES  = 300;
    // Quiet cycles at the end, to catch stray events after the last expected one.
    localparam int DRAIN_CYCLES = 16;
    localparam int SCRIPT_LEN   = 28;

    // Status bytes that fall outside every legal class, by range.
    localparam logic [7:0] BAD_DATA_HI   = mtep_pkg::STATUS_NOTE_LO - 8'd1;
    localparam logic [7:0] BAD_SYSTEM_LO = mtep_pkg::STATUS_SYSEX + 8'd1;
    localparam logic [7:0] BAD_SYSTEM_HI = mtep_pkg::STATUS_SYSEX_CT - 8'd1;
    localparam logic [7:0] BAD_REALT_LO  = mtep_pkg::STATUS_SYSEX_CT + 8'd1;
    localparam logic [7:0] BAD_REALT_HI  = mtep_pkg::STATUS_META - 8'd1;

    // One event as it leaves the block.
    typedef struct packed {
        mtep_pkg::t_kind               kind;
        logic [mtep_pkg::DELTA_W-1:0]  delta;
        logic [mtep_pkg::KEY_W-1:0]    key;
        logic [mtep_pkg::TEMPO_W-1:0]  tempo;
    } t_midi_event;

    // One row of the directed script. When typed is set, the event in the row is
    // the one the byte must produce; otherwise the predictor decides.
    typedef struct packed {
        logic [7:0]  data;
        logic        track_start;
        logic        typed;
        t_midi_event ev;
    } t_script_row;

    // One byte of the random track body.
    typedef struct packed {
        logic [7:0] data;
        logic       track_start;
    } t_track_byte;

    // DUT connections. Every input starts at a known value.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte   = '0;
    logic        i_track_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [1:0]  o_event_kind;
    logic [27:0] o_delta_ticks;
    logic [6:0]  o_key_number;
    logic [23:0] o_tempo_value;

    // Predictor state, starting at the values the block holds after reset.
    mtep_pkg::t_phase              trk_phase     = mtep_pkg::PH_DELTA;
    logic [mtep_pkg::DELTA_W-1:0]  trk_delta     = '0;
    logic [1:0]                    trk_vlq_count = '0;
    logic [7:0]                    trk_status    = '0;
    logic [7:0]                    trk_meta      = '0;
    logic [mtep_pkg::DELTA_W-1:0]  trk_remaining = '0;
    logic [1:0]                    trk_tempo_idx = '0;
    logic [mtep_pkg::TEMPO_W-1:0]  trk_tempo     = '0;
    logic [mtep_pkg::KEY_W-1:0]    trk_key       = '0;

    // Events predicted for accepted bytes, oldest first.
    t_midi_event pending_events[$];
    t_track_byte track_stream[$];
    int          errors = 0;

    // Traffic shaping. The sender percentage is used only by the stimulus process;
    // the receiver percentage and the hold-off request are handed over with
    // nonblocking assignments.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req    = 1'b0;
    bit hold_taken  = 1'b0;
    int hold_left   = 0;
    // Set when the random track loses its framing, so the next event resyncs.
    bit stream_broken = 1'b0;

    t_script_row track_script [SCRIPT_LEN] = '{
        // Bad status right after reset: delta zero, tempo still zero.
        '{8'h00,                     1'b1, 1'b0, '0},
        '{8'h05,                     1'b0, 1'b1,
          '{mtep_pkg::KIND_BAD, 28'd0, 7'd0, 24'd0}},
        // Note with the largest one-byte delta and a key byte with its top bit set.
        '{8'h7F,                     1'b0, 1'b0, '0},
        '{mtep_pkg::STATUS_NOTE_LO,  1'b0, 1'b0, '0},
        '{8'hFF,                     1'b0, 1'b1,
          '{mtep_pkg::KIND_NOTE, 28'd127, 7'h7F, 24'd0}},
        '{8'h00,                     1'b0, 1'b0, '0},
        // Four continuation bytes: the quantity stops at the limit with every bit set.
        '{8'hFF,                     1'b0, 1'b0, '0},
        '{8'hFF,                     1'b0, 1'b0, '0},
        '{8'hFF,                     1'b0, 1'b0, '0},
        '{8'hFF,                     1'b0, 1'b0, '0},
        '{mtep_pkg::STATUS_META,     1'b0, 1'b0, '0},
        '{mtep_pkg::META_EOT,        1'b0, 1'b0, '0},
        '{8'h00,                     1'b0, 1'b1,
          '{mtep_pkg::KIND_EOT, 28'hFFFFFFF, 7'd0, 24'd0}},
        // Tempo change to the largest value.
        '{8'h00,                     1'b0, 1'b0, '0},
        '{mtep_pkg::STATUS_META,     1'b0, 1'b0, '0},
        '{mtep_pkg::META_TEMPO,      1'b0, 1'b0, '0},
        '{8'h03,                     1'b0, 1'b0, '0},
        '{8'hFF,                     1'b0, 1'b0, '0},
        '{8'hFF,                     1'b0, 1'b0, '0},
        '{8'hFF,                     1'b0, 1'b1,
          '{mtep_pkg::KIND_TEMPO, 28'd0, 7'd0, 24'hFFFFFF}},
        // A SysEx length cut short by track start, then a bad system status.
        '{8'h00,                     1'b0, 1'b0, '0},
        '{mtep_pkg::STATUS_SYSEX_CT, 1'b0, 1'b0, '0},
        '{8'h81,                     1'b0, 1'b0, '0},
        '{8'h01,                     1'b1, 1'b0, '0},
        '{BAD_REALT_HI,              1'b0, 1'b1,
          '{mtep_pkg::KIND_BAD, 28'd1, 7'd0, 24'hFFFFFF}},
        // Program change style status with a single data byte.
        '{8'h00,                     1'b0, 1'b0, '0},
        '{mtep_pkg::STATUS_ONE_HI,   1'b0, 1'b0, '0},
        '{8'h40,                     1'b0, 1'b0, '0}
    };

    midi_track_event_parser_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_track_start (i_track_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_kind  (o_event_kind),
        .o_delta_ticks (o_delta_ticks),
        .o_key_number  (o_key_number),
        .o_tempo_value (o_tempo_value)
    );

    // 4 ns clock, 2 ns high and 2 ns low.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Adds one byte to a variable-length quantity held in acc. Returns 1 once the
    // quantity is complete, either on a byte without continuation or at the limit.
    function automatic logic vlq_absorb(inout logic [mtep_pkg::DELTA_W-1:0] acc,
                                        input logic [7:0] b);
        logic [mtep_pkg::DELTA_W-1:0] base;
        base = (trk_vlq_count == 2'd0) ? '0 : (acc << 7);
        acc  = base | mtep_pkg::DELTA_W'(b[6:0]);
        if (b[7] && (int'(trk_vlq_count) + 1 < VLQ_MAX)) begin
            trk_vlq_count = trk_vlq_count + 2'd1;
            return 1'b0;
        end
        trk_vlq_count = 2'd0;
        return 1'b1;
    endfunction

    // Advances the predicted parser by one byte and reports the event it causes.
    task automatic parse_track_byte(input logic [7:0] b, input logic ts,
                                    output logic fired, output t_midi_event ev);
        mtep_pkg::t_kind            kind;
        logic [mtep_pkg::KEY_W-1:0] key;
        fired = 1'b0;
        kind  = mtep_pkg::KIND_NOTE;
        key   = '0;
        // Track start overrides whatever phase the parser was in.
        if (ts) begin
            trk_phase     = mtep_pkg::PH_DELTA;
            trk_vlq_count = '0;
        end
        case (trk_phase)
            mtep_pkg::PH_DELTA: begin
                if (vlq_absorb(trk_delta, b)) trk_phase = mtep_pkg::PH_STATUS;
            end
            mtep_pkg::PH_STATUS: begin
                trk_status    = b;
                trk_vlq_count = '0;
                if (b >= mtep_pkg::STATUS_NOTE_LO && b <= mtep_pkg::STATUS_NOTE_HI) begin
                    trk_phase = mtep_pkg::PH_KEY;
                end else if (b >= mtep_pkg::STATUS_TWO_LO
                             && b <= mtep_pkg::STATUS_TWO_HI) begin
                    trk_remaining = 28'd2;
                    trk_phase     = mtep_pkg::PH_SKIP;
                end else if (b >= mtep_pkg::STATUS_ONE_LO
                             && b <= mtep_pkg::STATUS_ONE_HI) begin
                    trk_remaining = 28'd1;
                    trk_phase     = mtep_pkg::PH_SKIP;
                end else if (b >= mtep_pkg::STATUS_BEND_LO
                             && b <= mtep_pkg::STATUS_BEND_HI) begin
                    trk_remaining = 28'd2;
                    trk_phase     = mtep_pkg::PH_SKIP;
                end else if (b == mtep_pkg::STATUS_SYSEX
                             || b == mtep_pkg::STATUS_SYSEX_CT) begin
                    trk_phase = mtep_pkg::PH_LEN;
                end else if (b == mtep_pkg::STATUS_META) begin
                    trk_phase = mtep_pkg::PH_MTYPE;
                end else begin
                    // No running status: a bad status byte reports and resyncs.
                    fired     = 1'b1;
                    kind      = mtep_pkg::KIND_BAD;
                    trk_phase = mtep_pkg::PH_DELTA;
                end
            end
            mtep_pkg::PH_KEY: begin
                trk_key       = b[6:0];
                fired         = 1'b1;
                kind          = mtep_pkg::KIND_NOTE;
                key           = trk_key;
                trk_remaining = 28'd1;
                trk_phase     = mtep_pkg::PH_SKIP;
            end
            mtep_pkg::PH_MTYPE: begin
                trk_meta      = b;
                trk_vlq_count = '0;
                trk_phase     = mtep_pkg::PH_LEN;
            end
            mtep_pkg::PH_LEN: begin
                if (vlq_absorb(trk_remaining, b)) begin
                    if (trk_status == mtep_pkg::STATUS_META
                        && trk_meta == mtep_pkg::META_EOT) begin
                        // End of track fires whatever length it claims.
                        fired     = 1'b1;
                        kind      = mtep_pkg::KIND_EOT;
                        trk_phase = mtep_pkg::PH_DELTA;
                    end else if (trk_status == mtep_pkg::STATUS_META
                                 && trk_meta == mtep_pkg::META_TEMPO) begin
                        trk_tempo_idx = '0;
                        if (trk_remaining == '0) begin
                            fired     = 1'b1;
                            kind      = mtep_pkg::KIND_TEMPO;
                            trk_phase = mtep_pkg::PH_DELTA;
                        end else begin
                            trk_phase = mtep_pkg::PH_TEMPO;
                        end
                    end else begin
                        trk_phase = (trk_remaining == '0) ? mtep_pkg::PH_DELTA
                                                          : mtep_pkg::PH_SKIP;
                    end
                end
            end
            mtep_pkg::PH_SKIP: begin
                if (trk_remaining != '0) trk_remaining = trk_remaining - 28'd1;
                if (trk_remaining == '0) trk_phase = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_TEMPO: begin
                // Only the first three payload bytes reach the tempo register.
                if (trk_tempo_idx < 2'd3) begin
                    trk_tempo     = {trk_tempo[15:0], b};
                    trk_tempo_idx = trk_tempo_idx + 2'd1;
                end
                if (trk_remaining != '0) trk_remaining = trk_remaining - 28'd1;
                if (trk_remaining == '0) begin
                    fired     = 1'b1;
                    kind      = mtep_pkg::KIND_TEMPO;
                    trk_phase = mtep_pkg::PH_DELTA;
                end
            end
            default: begin
                trk_phase     = mtep_pkg::PH_DELTA;
                trk_vlq_count = '0;
            end
        endcase
        ev = '{kind, trk_delta, key, trk_tempo};
    endtask

    // Appends n data bytes. Data bytes are mostly 7-bit, as in a real file, and now
    // and then carry a stray track start that breaks the current event.
    task automatic append_payload(input int n);
        logic [7:0] d;
        logic       ts;
        repeat (n) begin
            d  = ($urandom_range(7) == 0) ? 8'($urandom) : {1'b0, 7'($urandom)};
            ts = ($urandom_range(49) == 0);
            if (ts) stream_broken = 1'b1;
            track_stream.push_back('{d, ts});
        end
    endtask

    // Appends a variable-length quantity. Small values are sometimes padded with
    // leading zero groups. The overlong form is four continuation bytes, so the
    // parser has to stop at its limit; its value is the low group of value.
    task automatic append_quantity(input logic [27:0] value, input logic first_ts,
                                   input logic overlong);
        logic [6:0]  groups[$];
        logic [27:0] rest;
        int          pad;
        if (overlong) begin
            for (int k = 0; k < VLQ_MAX; k++) begin
                track_stream.push_back('{{1'b1, (k == VLQ_MAX - 1) ? value[6:0] : 7'd0},
                                         (k == 0) ? first_ts : 1'b0});
            end
            return;
        end
        rest = value;
        do begin
            groups.push_front(rest[6:0]);
            rest = rest >> 7;
        end while (rest != '0);
        pad = ($urandom_range(3) == 0) ? $urandom_range(VLQ_MAX - groups.size()) : 0;
        repeat (pad) groups.push_front(7'd0);
        foreach (groups[k]) begin
            track_stream.push_back('{{(k != groups.size() - 1), groups[k]},
                                     (k == 0) ? first_ts : 1'b0});
        end
    endtask

    // Builds a random track body, mostly well-formed events with random content;
    // the rest is stray bytes, stray track starts, bad status bytes and oversized
    // end of track lengths. After any break the next event starts with track start.
    task automatic build_random_track(input int target);
        int          pick;
        int          len;
        logic [27:0] dval;
        logic [7:0]  status;
        logic [7:0]  mtype;
        while (track_stream.size() < target) begin
            if ($urandom_range(99) < 4) begin
                track_stream.push_back('{8'($urandom), 1'($urandom)});
                stream_broken = 1'b1;
                continue;
            end
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: dval = 28'($urandom_range(127));
                6, 7:             dval = 28'($urandom_range(16383));
                8:                dval = 28'($urandom_range(2097151));
                default:          dval = 28'($urandom);
            endcase
            append_quantity(dval, stream_broken || ($urandom_range(7) == 0),
                            $urandom_range(19) == 0);
            stream_broken = 1'b0;
            pick = $urandom_range(99);
            if (pick < 30) begin
                status = 8'($urandom_range(mtep_pkg::STATUS_NOTE_HI,
                                           mtep_pkg::STATUS_NOTE_LO));
                track_stream.push_back('{status, 1'b0});
                append_payload(2);
            end else if (pick < 55) begin
                status = 8'($urandom_range(mtep_pkg::STATUS_BEND_HI,
                                           mtep_pkg::STATUS_TWO_LO));
                track_stream.push_back('{status, 1'b0});
                append_payload((status >= mtep_pkg::STATUS_ONE_LO
                                && status <= mtep_pkg::STATUS_ONE_HI) ? 1 : 2);
            end else if (pick < 65) begin
                status = ($urandom_range(1) != 0) ? mtep_pkg::STATUS_SYSEX
                                                  : mtep_pkg::STATUS_SYSEX_CT;
                track_stream.push_back('{status, 1'b0});
                len = $urandom_range(6);
                append_quantity(28'(len), 1'b0, $urandom_range(24) == 0);
                append_payload(len);
            end else if (pick < 73) begin
                track_stream.push_back('{mtep_pkg::STATUS_META, 1'b0});
                track_stream.push_back('{mtep_pkg::META_TEMPO, 1'b0});
                len = ($urandom_range(3) == 0) ? $urandom_range(5) : 3;
                append_quantity(28'(len), 1'b0, $urandom_range(24) == 0);
                append_payload(len);
            end else if (pick < 78) begin
                track_stream.push_back('{mtep_pkg::STATUS_META, 1'b0});
                track_stream.push_back('{mtep_pkg::META_EOT, 1'b0});
                len = ($urandom_range(3) == 0) ? $urandom_range(3) : 0;
                append_quantity(28'(len), 1'b0, $urandom_range(24) == 0);
                // The parser does not skip an end of track payload, so these bytes
                // are read as the next delta time and the framing is lost.
                if (len != 0 && $urandom_range(1) != 0) begin
                    append_payload(len);
                    stream_broken = 1'b1;
                end
            end else if (pick < 88) begin
                mtype = 8'($urandom);
                track_stream.push_back('{mtep_pkg::STATUS_META, 1'b0});
                track_stream.push_back('{mtype, 1'b0});
                len = $urandom_range(8);
                append_quantity(28'(len), 1'b0, $urandom_range(24) == 0);
                append_payload(len);
                if (mtype == mtep_pkg::META_EOT && len != 0) stream_broken = 1'b1;
            end else begin
                case ($urandom_range(2))
                    0:       status = 8'($urandom_range(BAD_DATA_HI));
                    1:       status = 8'($urandom_range(BAD_SYSTEM_HI, BAD_SYSTEM_LO));
                    default: status = 8'($urandom_range(BAD_REALT_HI, BAD_REALT_LO));
                endcase
                track_stream.push_back('{status, 1'b0});
            end
        end
    endtask

    // Offers one byte, holding valid and payload until the transaction completes.
    // Ready is looked at on the falling edge, where every signal is settled, so the
    // byte is known to be taken at the next rising edge. The predictor runs then and
    // its event joins the queue of pending events.
    task automatic offer_byte(input logic [7:0] b, input logic ts, input logic typed,
                              input t_midi_event typed_ev);
        logic        fired;
        t_midi_event ev;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_track_start <= ts;
        @(negedge i_clk);
        while (o_in_ready !== 1'b1) @(negedge i_clk);
        parse_track_byte(b, ts, fired, ev);
        if (typed) begin
            pending_events.push_back(typed_ev);
        end else if (fired) begin
            pending_events.push_back(ev);
        end
        @(posedge i_clk);
    endtask

    // Receiver: random back-pressure, plus one long hold-off when requested. The
    // hold-off is counted here so the sender keeps offering bytes meanwhile.
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Event checker. A result transaction is seen on the falling edge before the
    // rising edge that completes it and is compared with the oldest pending event.
    always @(negedge i_clk) begin : check_events
        t_midi_event want;
        logic        bad_field;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_events.size() == 0) begin
                errors++;
                $display("%0t: no event expected, got kind %0d delta %0d key %0d tempo %0d",
                         $time, o_event_kind, o_delta_ticks, o_key_number, o_tempo_value);
            end else begin
                want      = pending_events.pop_front();
                bad_field = 1'b0;
                if (o_event_kind !== want.kind) begin
                    $display("%0t: event_kind expected %0d got %0d",
                             $time, want.kind, o_event_kind);
                    bad_field = 1'b1;
                end
                if (o_delta_ticks !== want.delta) begin
                    $display("%0t: delta_ticks expected %0d got %0d",
                             $time, want.delta, o_delta_ticks);
                    bad_field = 1'b1;
                end
                if (o_key_number !== want.key) begin
                    $display("%0t: key_number expected %0d got %0d",
                             $time, want.key, o_key_number);
                    bad_field = 1'b1;
                end
                if (o_tempo_value !== want.tempo) begin
                    $display("%0t: tempo_value expected %0d got %0d",
                             $time, want.tempo, o_tempo_value);
                    bad_field = 1'b1;
                end
                if (bad_field) errors++;
            end
        end
    end

    // Stimulus: reset, directed script, then the random track in three traffic
    // phases. The first phase idles the sender lightly and the receiver heavily,
    // the second swaps them after a full drain, and the third runs flat out and
    // contains the long receiver hold-off.
    initial begin : stimulus
        int n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 37;
        rx_idle_pct <= 61;
        foreach (track_script[r]) begin
            offer_byte(track_script[r].data, track_script[r].track_start,
                       track_script[r].typed, track_script[r].ev);
        end

        build_random_track(RANDOM_ITEMS);
        n = track_stream.size();
        for (int i = 0; i < n; i++) begin
            if (i == n / 3) begin
                // The sender pauses until every pending event has come out.
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending_events.size() != 0);
                tx_idle_pct = 61;
                rx_idle_pct <= 37;
            end
            if (i == (2 * n) / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            if (i == (2 * n) / 3 + 50) hold_req <= 1'b1;
            offer_byte(track_stream[i].data, track_stream[i].track_start, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        // Wait for the last events, then a few quiet cycles to catch strays.
        do @(posedge i_clk); while (pending_events.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS midi_track_event_parser_top");
        end else begin
            $display("FAIL midi_track_event_parser_top");
        end
        $finish;
    end

    // Watchdog: a correct run ends in well under a tenth of this time.
    initial begin
        #400_000;
        $display("FAIL midi_track_event_parser_top");
        $finish;
    end

endmodule

[sim.f]
src/mtep_pkg.sv
src/mtep_front.sv
src/mtep_queue.sv
src/mtep_back.sv
src/midi_track_event_parser_top.sv
src/mtep_checker.sv
sim/tb_midi_track_event_parser_top.sv
